// ===== hdl/stpc_pkg.sv =====
// Shared types and constants for the seven-bit text pack codec.
// No dependencies; imported by every module of the block.
package stpc_pkg;

  localparam int BYTE_W = 8;
  localparam int GRP_MAX = 8;

  localparam logic [3:0] PACK_GRP = 4'd8;
  localparam logic [3:0] UNPACK_GRP = 4'd7;
  localparam logic [3:0] PACK_NOUT = 4'd7;
  localparam logic [3:0] UNPACK_NOUT = 4'd8;

  localparam logic MODE_PACK = 1'b0;
  localparam logic MODE_UNPACK = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              end_marker;
  } in_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_res_t;

  typedef enum logic [1:0] {
    JOB_PACK   = 2'd0,
    JOB_UNPACK = 2'd1,
    JOB_FLUSH  = 2'd2
  } job_kind_t;

  // One finished group (or a flush) handed from the front to the back.
  typedef struct packed {
    job_kind_t                     kind;
    logic [3:0]                    n_out;
    logic [GRP_MAX-1:0][BYTE_W-1:0] data;
  } job_t;

endpackage

// ===== hdl/seven_bit_text_pack_codec.sv =====
// Top level of the seven-bit text pack codec: front, job queue, back.
// Depends on stpc_pkg, stpc_front, stpc_jobq, stpc_back.
//
//   channel  ports                          direction  payload
//   input    in_push / in_full / in_req     in         in_req_t
//   result   out_pop / out_empty / out_res  out        out_res_t
//   config   cfg_we / cfg_wdata             in         codec_mode
//
// A request is taken every cycle while the two-entry job queue has room.
// The back part emits one result byte per cycle while out_pop keeps up, so a group
// yields 7 (pack) or 8 (unpack) result bytes; sustained rate is set by that single
// output register.
// Synchronous active-low reset empties the queue, the output and the held group.
// in_full follows the queue only; a stalled out_pop backs up into it.
module seven_bit_text_pack_codec import stpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_req_t  in_req,
  output logic     out_empty,
  input  logic     out_pop,
  output out_res_t out_res,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic job_push, q_full, q_avail, job_done;
  job_t job_in, job_head;

  stpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  stpc_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (job_done),
    .full     (q_full),
    .avail    (q_avail),
    .head     (job_head)
  );

  stpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (q_avail),
    .job       (job_head),
    .job_done  (job_done),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

endmodule

// ===== hdl/stpc_front.sv =====
// Front part: takes requests, gathers bytes into a group, holds the mode register.
// Hands finished groups and flushes to the job queue. Uses stpc_pkg.
module stpc_front import stpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  output logic    in_full,
  input  in_req_t in_req,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  input  logic    q_full,
  output logic    job_push,
  output job_t    job
);

  logic [BYTE_W-1:0] grp_r [GRP_MAX];
  logic [3:0]        cnt_r, cnt_nxt;
  logic              mode_r, mode_nxt;
  logic              accept;
  logic              grp_done;
  logic [3:0]        grp_size;

  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign grp_size = (mode_r == MODE_UNPACK) ? UNPACK_GRP : PACK_GRP;
  assign grp_done = ((cnt_r + 4'd1) == grp_size);

  // The job carries the current byte in the slot it would occupy.
  always_comb begin
    for (int k = 0; k < GRP_MAX; k++) begin
      job.data[k] = (3'(k) == cnt_r[2:0]) ? in_req.byte_value : grp_r[k];
    end
    if (in_req.end_marker) begin
      job.kind  = JOB_FLUSH;
      job.n_out = cnt_r;
    end else if (mode_r == MODE_UNPACK) begin
      job.kind  = JOB_UNPACK;
      job.n_out = UNPACK_NOUT;
    end else begin
      job.kind  = JOB_PACK;
      job.n_out = PACK_NOUT;
    end
  end

  assign job_push = accept && (in_req.end_marker ? (cnt_r != 4'd0) : grp_done);

  always_comb begin
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    if (cfg_we) begin
      mode_nxt = cfg_wdata;
      cnt_nxt  = 4'd0;
    end else if (accept) begin
      if (in_req.end_marker || grp_done) begin
        cnt_nxt = 4'd0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      mode_r <= MODE_PACK;
    end else begin
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_req.end_marker && !grp_done) begin
      grp_r[cnt_r[2:0]] <= in_req.byte_value;
    end
  end

endmodule

// ===== hdl/stpc_jobq.sv =====
// Two-entry job queue between front and back parts.
// Uses job_t from stpc_pkg.
module stpc_jobq import stpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic avail,
  output job_t head
);

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/stpc_back.sv =====
// Back part: walks the head job one result byte per cycle into the output register
// when it is free or popped. Uses stpc_pkg; the job comes from stpc_jobq.
module stpc_back import stpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_avail,
  input  job_t     job,
  output logic     job_done,
  output logic     out_empty,
  input  logic     out_pop,
  output out_res_t out_res
);

  logic [2:0]        idx_r;
  logic              out_vld_r;
  out_res_t          out_r;
  logic              adv;
  logic              last;
  logic [BYTE_W-1:0] res_byte;
  logic [2:0]        idx_p1, idx_m1, bit_sel;

  assign adv      = job_avail && (!out_vld_r || out_pop);
  assign last     = ({1'b0, idx_r} == (job.n_out - 4'd1));
  assign job_done = adv && last;
  assign idx_p1   = idx_r + 3'd1;
  assign idx_m1   = idx_r - 3'd1;
  assign bit_sel  = 3'd6 - idx_r;

  always_comb begin
    unique case (job.kind)
      JOB_PACK: begin
        // byte 0 lends its bit 6 down to bit 0 to the tops of bytes 1 to 7
        res_byte = job.data[idx_p1] | {job.data[0][bit_sel], 7'd0};
      end
      JOB_UNPACK: begin
        if (idx_r == 3'd0) begin
          res_byte = {1'b0, job.data[0][7], job.data[1][7], job.data[2][7],
                      job.data[3][7], job.data[4][7], job.data[5][7], job.data[6][7]};
        end else begin
          res_byte = {1'b0, job.data[idx_m1][6:0]};
        end
      end
      JOB_FLUSH: res_byte = job.data[idx_r];
      default:   res_byte = job.data[idx_r];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 3'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_r <= 1'b1;
        idx_r     <= last ? 3'd0 : idx_p1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_byte    <= res_byte;
      out_r.last_of_run <= last;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_res   = out_r;

endmodule

// ===== hdl/stpc_chk.sv =====
// Port-level checker for seven_bit_text_pack_codec, bound to the top level.
// Uses stpc_pkg types.
module stpc_chk import stpc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_full,
  input logic     out_empty,
  input logic     out_pop,
  input out_res_t out_res
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_res)))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("not empty after reset");

  // mid-run bytes follow back to back
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_res.last_of_run) |=> !out_empty)
    else $error("gap inside a run");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |=> !out_empty)
    else $error("queue full but no result shown");

endmodule

bind seven_bit_text_pack_codec stpc_chk u_stpc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_res   (out_res)
);
